// File: rtl/core/bnfa_pkg.sv
`default_nettype none

package bnfa_pkg;

  // field and register widths
  localparam int CFG_W     = 13;
  localparam int IDX_W     = 12;
  localparam int CFG_IDX_W = 2;

  // bitmap word organization
  localparam int WORD_W  = 32;
  localparam int OFF_W   = 5;
  localparam int WPOS_W  = CFG_W - OFF_W;
  localparam int MAX_POS = (1 << CFG_W) - 1;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_TOTAL = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FIRST = 2'd1;

  // request codes
  localparam logic ACT_ALLOC = 1'b0;
  localparam logic ACT_TAS   = 1'b1;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_NOSPACE = 2'd1,
    ST_RANGE   = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_SCAN,
    S_TAS
  } scan_state_t;

  // search window handed to the scan engine
  typedef struct packed {
    logic [CFG_W-1:0] start;
    logic [CFG_W-1:0] limit;
  } scan_req_t;

  // one finished request
  typedef struct packed {
    logic             done;
    status_t          status;
    logic [CFG_W-1:0] idx;
    logic             was_set;
    logic             hint_we;
  } scan_res_t;

  // lowest set bit: {found, position}
  function automatic logic [OFF_W:0] ffs_word(input logic [WORD_W-1:0] v);
    logic [WORD_W-1:0] low;
    logic [OFF_W-1:0]  pos;
    low = v & (~v + WORD_W'(1));
    pos = '0;
    for (int i = 0; i < WORD_W; i++) begin
      if (low[i]) begin
        pos = pos | OFF_W'(i);
      end
    end
    return {|v, pos};
  endfunction

endpackage

`default_nettype wire

// File: rtl/core/bnfa_scan.sv
`default_nettype none

module bnfa_scan import bnfa_pkg::*; #(
  parameter int ENTRIES = 4096
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  input  wire logic             action,
  input  wire logic [IDX_W-1:0] index,
  input  wire scan_req_t        req,
  output logic                  busy,
  output scan_res_t             res
);

  localparam int WORDS = (ENTRIES + WORD_W - 1) / WORD_W;
  localparam int AW    = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam logic [AW-1:0] LAST_ADDR = AW'(WORDS - 1);

  logic [WORD_W-1:0] mem [WORDS];
  logic [WORD_W-1:0] rd_data_r;

  scan_state_t state_r, state_nxt;
  logic [AW-1:0]     clr_r, clr_nxt;
  logic [WPOS_W-1:0] word_r, word_nxt;
  logic [WPOS_W-1:0] last_word_r, last_word_nxt;
  logic [OFF_W-1:0]  lo_off_r, lo_off_nxt;
  logic [OFF_W-1:0]  last_off_r, last_off_nxt;
  logic [OFF_W-1:0]  bit_off_r, bit_off_nxt;
  logic              first_r, first_nxt;

  logic              accept;
  logic              alloc_ok;
  logic              tas_ok;
  logic [CFG_W-1:0]  lim_m1;
  logic [CFG_W-1:0]  tas_pos;
  logic [OFF_W-1:0]  lo_off;
  logic [WORD_W-1:0] cand;
  logic [OFF_W:0]    hit;
  logic              at_last;

  logic              mem_we, mem_re;
  logic [AW-1:0]     mem_waddr, mem_raddr;
  logic [WORD_W-1:0] mem_wdata;

  assign busy     = (state_r != S_IDLE);
  assign accept   = start && (state_r == S_IDLE);
  assign tas_pos  = {1'b0, index};
  assign alloc_ok = (req.start < req.limit);
  assign tas_ok   = (tas_pos < req.limit);
  assign lim_m1   = req.limit - CFG_W'(1);

  // candidate free bits inside the current word
  assign at_last = (word_r == last_word_r);
  assign lo_off  = first_r ? lo_off_r : '0;
  assign cand    = ~rd_data_r
                 & ({WORD_W{1'b1}} << lo_off)
                 & (at_last ? ({WORD_W{1'b1}} >> (OFF_W'(WORD_W - 1) - last_off_r))
                            : {WORD_W{1'b1}});
  assign hit     = ffs_word(cand);

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_CLEAR: begin
        if (clr_r == LAST_ADDR) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (accept) begin
          if (action == ACT_ALLOC && alloc_ok) state_nxt = S_SCAN;
          else if (action == ACT_TAS && tas_ok) state_nxt = S_TAS;
        end
      end
      S_SCAN: begin
        if (hit[OFF_W] || at_last) state_nxt = S_IDLE;
      end
      S_TAS: begin
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // outputs: memory port and result
  always_comb begin
    mem_we      = 1'b0;
    mem_re      = 1'b0;
    mem_waddr   = AW'(word_r);
    mem_raddr   = AW'(req.start[CFG_W-1:OFF_W]);
    mem_wdata   = rd_data_r;
    res         = '0;
    res.status  = ST_OK;
    case (state_r)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_r;
        mem_wdata = '0;
      end
      S_IDLE: begin
        if (accept) begin
          if (action == ACT_ALLOC) begin
            if (alloc_ok) begin
              mem_re = 1'b1;
            end else begin
              res.done   = 1'b1;
              res.status = ST_NOSPACE;
            end
          end else begin
            mem_raddr = AW'(tas_pos[CFG_W-1:OFF_W]);
            if (tas_ok) begin
              mem_re = 1'b1;
            end else begin
              res.done   = 1'b1;
              res.status = ST_RANGE;
            end
          end
        end
      end
      S_SCAN: begin
        mem_raddr = AW'(word_r + WPOS_W'(1));
        if (hit[OFF_W]) begin
          mem_we      = 1'b1;
          mem_wdata   = rd_data_r | (WORD_W'(1) << hit[OFF_W-1:0]);
          res.done    = 1'b1;
          res.idx     = {word_r, hit[OFF_W-1:0]};
          res.hint_we = 1'b1;
        end else if (at_last) begin
          res.done   = 1'b1;
          res.status = ST_NOSPACE;
        end else begin
          mem_re = 1'b1;
        end
      end
      S_TAS: begin
        mem_we      = 1'b1;
        mem_wdata   = rd_data_r | (WORD_W'(1) << bit_off_r);
        res.done    = 1'b1;
        res.idx     = {word_r, bit_off_r};
        res.was_set = rd_data_r[bit_off_r];
      end
      default: ;
    endcase
  end

  // working registers
  always_comb begin
    clr_nxt       = clr_r;
    word_nxt      = word_r;
    last_word_nxt = last_word_r;
    lo_off_nxt    = lo_off_r;
    last_off_nxt  = last_off_r;
    bit_off_nxt   = bit_off_r;
    first_nxt     = first_r;
    case (state_r)
      S_CLEAR: clr_nxt = clr_r + AW'(1);
      S_IDLE: begin
        if (action == ACT_ALLOC) begin
          word_nxt      = req.start[CFG_W-1:OFF_W];
          lo_off_nxt    = req.start[OFF_W-1:0];
          last_word_nxt = lim_m1[CFG_W-1:OFF_W];
          last_off_nxt  = lim_m1[OFF_W-1:0];
          first_nxt     = 1'b1;
        end else begin
          word_nxt    = tas_pos[CFG_W-1:OFF_W];
          bit_off_nxt = tas_pos[OFF_W-1:0];
        end
      end
      S_SCAN: begin
        word_nxt  = word_r + WPOS_W'(1);
        first_nxt = 1'b0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      clr_r   <= '0;
    end else begin
      state_r <= state_nxt;
      clr_r   <= clr_nxt;
    end
  end

  always_ff @(posedge clk) begin
    word_r      <= word_nxt;
    last_word_r <= last_word_nxt;
    lo_off_r    <= lo_off_nxt;
    last_off_r  <= last_off_nxt;
    bit_off_r   <= bit_off_nxt;
    first_r     <= first_nxt;
  end

  // bitmap memory, one write and one read port
  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    if (mem_re) rd_data_r <= mem[mem_raddr];
  end

`ifndef SYNTHESIS
  a_no_done_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    res.done |-> state_r != S_CLEAR)
    else $error("result during clearing pass");

  a_done_returns_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (res.done && state_r != S_IDLE) |=> state_r == S_IDLE)
    else $error("engine stayed busy after finishing");

  a_alloc_in_window: assert property (@(posedge clk) disable iff (!rst_n)
    (res.done && state_r == S_SCAN && res.status == ST_OK)
      |-> (res.idx < req.limit && res.idx >= req.start))
    else $error("allocation outside search window");

  a_no_rw_collision: assert property (@(posedge clk) disable iff (!rst_n)
    (mem_we && mem_re) |-> mem_waddr != mem_raddr)
    else $error("read and write hit the same word");
`endif

endmodule

`default_nettype wire

// File: rtl/core/bitmap_next_fit_allocator.sv
// Channel  | Ports                                   | Handshake
// ---------+-----------------------------------------+--------------------------------
// request  | in_action, in_index                     | taken when start && !busy
// result   | out_status, out_result_index, out_was_set | out_valid, one cycle, no stall
// config   | cfg_index, cfg_wdata                    | written when cfg_we
//
// After reset the bitmap memory is cleared one 32-bit word a cycle, busy high throughout.
// Out-of-range test-and-set or an empty search window: result in the cycle after accept.
// Test-and-set: read, then modify/write in S_TAS; the result is registered from that state.
// Allocate: one bitmap word examined per cycle; the result is registered when a free bit
// is found or the last word of the search window has been examined.
// One request in flight; busy is the only stall, the result side never waits.
`default_nettype none

module bitmap_next_fit_allocator import bnfa_pkg::*; #(
  parameter int ENTRIES = 4096
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  // request word
  input  wire logic                 start,
  output logic                      busy,
  input  wire logic                 in_action,
  input  wire logic [IDX_W-1:0]     in_index,
  // result word
  output logic                      out_valid,
  output logic [1:0]                out_status,
  output logic [IDX_W-1:0]          out_result_index,
  output logic                      out_was_set,
  // config
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]     cfg_wdata
);

  // search limit never exceeds the physical bitmap size
  localparam int LIM_CAP = (ENTRIES > MAX_POS) ? MAX_POS : ENTRIES;
  localparam logic [CFG_W-1:0] LIM_CAP_V = CFG_W'(LIM_CAP);

  logic [CFG_W-1:0] total_r, total_nxt;
  logic [CFG_W-1:0] first_r, first_nxt;
  logic [CFG_W-1:0] hint_r, hint_nxt;

  logic             out_valid_r;
  status_t          out_status_r;
  logic [IDX_W-1:0] out_index_r;
  logic             out_was_set_r;

  scan_req_t req;
  scan_res_t res;

  // next-fit start is the larger of hint and first usable entry
  assign req.start = (hint_r > first_r) ? hint_r : first_r;
  assign req.limit = (total_r < LIM_CAP_V) ? total_r : LIM_CAP_V;

  bnfa_scan #(
    .ENTRIES (ENTRIES)
  ) u_scan (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .action (in_action),
    .index  (in_index),
    .req    (req),
    .busy   (busy),
    .res    (res)
  );

  // config writes and hint update after a successful allocate; writing first_usable also reloads the hint
  always_comb begin
    total_nxt = total_r;
    first_nxt = first_r;
    hint_nxt  = hint_r;
    if (res.hint_we) hint_nxt = res.idx + CFG_W'(1);
    if (cfg_we) begin
      case (cfg_index)
        REG_TOTAL: total_nxt = cfg_wdata;
        REG_FIRST: begin
          first_nxt = cfg_wdata;
          hint_nxt  = cfg_wdata;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      total_r     <= CFG_W'(4096);
      first_r     <= CFG_W'(1);
      hint_r      <= CFG_W'(1);
      out_valid_r <= 1'b0;
    end else begin
      total_r     <= total_nxt;
      first_r     <= first_nxt;
      hint_r      <= hint_nxt;
      out_valid_r <= res.done;
    end
  end

  // result register; index and was_set fields are zero on failure from the engine
  always_ff @(posedge clk) begin
    if (res.done) begin
      out_status_r  <= res.status;
      out_index_r   <= res.idx[IDX_W-1:0];
      out_was_set_r <= res.was_set;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_status       = 2'(out_status_r);
  assign out_result_index = out_index_r;
  assign out_was_set      = out_was_set_r;

endmodule

`default_nettype wire

// File: sim/testbench.sv
`timescale 1ns / 100ps

module testbench;
  import bnfa_pkg::*;

  localparam int ENTRIES   = 4096;
  localparam int RUN_LIMIT = 500000;   // cycles
  localparam int TAIL_WAIT = 140;      // idle cycles after the final drain

  // register slots the block does not implement; writes must be dropped
  localparam logic [CFG_IDX_W-1:0] REG_SPARE2 = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE3 = 2'd3;

  // one result word as the block reports it
  typedef struct packed {
    status_t          status;
    logic [IDX_W-1:0] idx;
    logic             was_set;
  } alloc_result_t;

  typedef enum logic {
    ROW_WORD,
    ROW_REG
  } row_kind_t;

  // directed stimulus row: either a request word or a register write
  typedef struct packed {
    row_kind_t              kind;
    logic                   act;
    logic [IDX_W-1:0]       idx;
    logic [CFG_IDX_W-1:0]   reg_sel;
    logic [CFG_W-1:0]       reg_val;
    logic                   known;   // want is typed in, not predicted
    alloc_result_t          want;
  } plan_row_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 start = 1'b0;
  logic                 busy;
  logic                 in_action = ACT_ALLOC;
  logic [IDX_W-1:0]     in_index = '0;
  logic                 out_valid;
  logic [1:0]           out_status;
  logic [IDX_W-1:0]     out_result_index;
  logic                 out_was_set;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = REG_TOTAL;
  logic [CFG_W-1:0]     cfg_wdata = '0;

  // shadow of the allocator state, as it stands after reset
  bit                   used_bits [ENTRIES];
  logic [CFG_W-1:0]     lim_entries = 13'd4096;
  logic [CFG_W-1:0]     floor_entry = 13'd1;
  logic [CFG_W-1:0]     scan_hint   = 13'd1;

  alloc_result_t        owed_results [$];
  alloc_result_t        head_result;
  plan_row_t            plan [$];
  int unsigned          cycle_count = 0;
  int                   mismatch_count = 0;

  bitmap_next_fit_allocator #(.ENTRIES(ENTRIES)) u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_action        (in_action),
    .in_index         (in_index),
    .out_valid        (out_valid),
    .out_status       (out_status),
    .out_result_index (out_result_index),
    .out_was_set      (out_was_set),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
  end

  // Next-fit prediction for one accepted word; updates the shadow state.
  // Allocate scans up from max(hint, floor) below min(total, ENTRIES);
  // the hint only moves on success and never wraps.
  function automatic alloc_result_t predict_allocation(input logic act,
                                                       input logic [IDX_W-1:0] idx);
    alloc_result_t res;
    int            limit;
    int            b;
    logic          found;
    res = '0;
    res.status = ST_NOSPACE;
    limit = (int'(lim_entries) < ENTRIES) ? int'(lim_entries) : ENTRIES;
    if (act == ACT_ALLOC) begin
      b = (scan_hint > floor_entry) ? int'(scan_hint) : int'(floor_entry);
      found = 1'b0;
      while (!found && b < limit) begin
        if (!used_bits[b]) begin
          used_bits[b] = 1'b1;
          found = 1'b1;
          res.status = ST_OK;
          res.idx = IDX_W'(b);
          scan_hint = CFG_W'(b + 1);
        end else begin
          b++;
        end
      end
    end else if (int'(idx) >= limit) begin
      // out of range: bitmap untouched
      res.status = ST_RANGE;
    end else begin
      // test-and-set: hint is left alone even inside the allocatable window
      res.was_set = used_bits[idx];
      used_bits[idx] = 1'b1;
      res.status = ST_OK;
      res.idx = idx;
    end
    return res;
  endfunction

  function automatic plan_row_t word_row(input logic act, input logic [IDX_W-1:0] idx);
    plan_row_t row;
    row = '0;
    row.kind = ROW_WORD;
    row.act = act;
    row.idx = idx;
    return row;
  endfunction

  function automatic plan_row_t known_row(input logic act, input logic [IDX_W-1:0] idx,
                                          input status_t st, input logic [IDX_W-1:0] ri,
                                          input logic ws);
    plan_row_t row;
    row = word_row(act, idx);
    row.known = 1'b1;
    row.want.status = st;
    row.want.idx = ri;
    row.want.was_set = ws;
    return row;
  endfunction

  function automatic plan_row_t reg_row(input logic [CFG_IDX_W-1:0] sel,
                                        input logic [CFG_W-1:0] val);
    plan_row_t row;
    row = '0;
    row.kind = ROW_REG;
    row.reg_sel = sel;
    row.reg_val = val;
    return row;
  endfunction

  // idle cycles the sender leaves after a word, pct percent per cycle
  function automatic int idle_gap(input int pct);
    int n;
    n = 0;
    while (n < 30 && $urandom_range(99) < pct) n++;
    return n;
  endfunction

  // Present one request word and hold it until taken (start && !busy at an edge).
  // start stays high when gap is zero so a back-to-back word needs no re-raise.
  task automatic send_word(input logic act, input logic [IDX_W-1:0] idx, input int gap,
                           input logic known, input alloc_result_t want);
    alloc_result_t predicted;
    start <= 1'b1;
    in_action <= act;
    in_index <= idx;
    @(posedge clk);
    while (busy) @(posedge clk);
    predicted = predict_allocation(act, idx);
    owed_results.push_back(known ? want : predicted);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Wait until every owed result word is back and the block is idle.
  task automatic drain();
    while (owed_results.size() != 0 || busy) @(posedge clk);
    @(posedge clk);
  endtask

  // Single-cycle register write, then cfg_we is dropped and the shadow state updated before the task returns.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] sel, input logic [CFG_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= sel;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (sel == REG_TOTAL) begin
      lim_entries = val;
    end else if (sel == REG_FIRST) begin
      // floor write also reloads the hint
      floor_entry = val;
      scan_hint = val;
    end
    @(posedge clk);
  endtask

  // Result checker: every strobed word must match the oldest owed one.
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (owed_results.size() == 0) begin
        $error("result word with nothing owed: status %0d index %0d was_set %0d",
               out_status, out_result_index, out_was_set);
        mismatch_count++;
      end else begin
        head_result = owed_results.pop_front();
        if (out_status !== head_result.status) begin
          $error("out_status: expected %0d, actual %0d", head_result.status, out_status);
          mismatch_count++;
        end
        if (out_result_index !== head_result.idx) begin
          $error("out_result_index: expected %0d, actual %0d",
                 head_result.idx, out_result_index);
          mismatch_count++;
        end
        if (out_was_set !== head_result.was_set) begin
          $error("out_was_set: expected %0d, actual %0d",
                 head_result.was_set, out_was_set);
          mismatch_count++;
        end
      end
    end
  end

  // Hard stop if the block hangs or drops a result word.
  initial begin
    wait (cycle_count == RUN_LIMIT);
    $display("bitmap_next_fit_allocator test failed");
    $finish;
  end

  initial begin
    int               gap;
    int               pct;
    int               tot;
    int               fst;
    int               win_hi;
    int               r;
    logic             act;
    logic [IDX_W-1:0] idx;

    // Directed table. Reset state: total 4096, floor 1, hint 1, bitmap clear.
    plan.push_back(known_row(ACT_ALLOC, 12'd0,    ST_OK, 12'd1, 1'b0));
    plan.push_back(known_row(ACT_ALLOC, 12'd4095, ST_OK, 12'd2, 1'b0)); // index ignored
    plan.push_back(known_row(ACT_TAS,   12'd0,    ST_OK, 12'd0, 1'b0)); // below floor
    plan.push_back(known_row(ACT_TAS,   12'd0,    ST_OK, 12'd0, 1'b1)); // second hit
    plan.push_back(known_row(ACT_TAS,   12'd4095, ST_OK, 12'd4095, 1'b0)); // top entry
    plan.push_back(known_row(ACT_TAS,   12'd3,    ST_OK, 12'd3, 1'b0)); // at the hint
    plan.push_back(word_row(ACT_ALLOC, 12'd2730));                      // must skip 3
    plan.push_back(word_row(ACT_TAS,   12'd2048));
    // unimplemented register slots must not disturb anything
    plan.push_back(reg_row(REG_SPARE2, 13'd0));
    plan.push_back(reg_row(REG_SPARE3, 13'd8191));
    plan.push_back(word_row(ACT_ALLOC, 12'd1365));
    // empty window: allocate finds nothing, every index is out of range
    plan.push_back(reg_row(REG_TOTAL, 13'd0));
    plan.push_back(known_row(ACT_ALLOC, 12'd0, ST_NOSPACE, 12'd0, 1'b0));
    plan.push_back(known_row(ACT_TAS,   12'd0, ST_RANGE,   12'd0, 1'b0));
    // total above the bitmap size clamps to ENTRIES
    plan.push_back(reg_row(REG_TOTAL, 13'd8191));
    plan.push_back(known_row(ACT_TAS, 12'd4095, ST_OK, 12'd4095, 1'b1));
    plan.push_back(word_row(ACT_ALLOC, 12'd0));
    // search start at or past the limit
    plan.push_back(reg_row(REG_FIRST, 13'd4096));
    plan.push_back(known_row(ACT_ALLOC, 12'd0, ST_NOSPACE, 12'd0, 1'b0));
    plan.push_back(reg_row(REG_FIRST, 13'd8191));
    plan.push_back(known_row(ACT_ALLOC, 12'd0, ST_NOSPACE, 12'd0, 1'b0));
    // tiny window: fill it, then run dry
    plan.push_back(reg_row(REG_TOTAL, 13'd8));
    plan.push_back(reg_row(REG_FIRST, 13'd0));
    plan.push_back(word_row(ACT_ALLOC, 12'd0));
    plan.push_back(word_row(ACT_ALLOC, 12'd0));
    plan.push_back(word_row(ACT_TAS,   12'd7));
    plan.push_back(known_row(ACT_TAS,  12'd8, ST_RANGE, 12'd0, 1'b0)); // exactly at limit
    // fresh region, then move the floor below the hint
    plan.push_back(reg_row(REG_TOTAL, 13'd4096));
    plan.push_back(reg_row(REG_FIRST, 13'd100));
    plan.push_back(known_row(ACT_ALLOC, 12'd0,   ST_OK, 12'd100, 1'b0));
    plan.push_back(known_row(ACT_TAS,   12'd101, ST_OK, 12'd101, 1'b0));
    plan.push_back(word_row(ACT_ALLOC, 12'd0));
    plan.push_back(reg_row(REG_FIRST, 13'd50));
    plan.push_back(word_row(ACT_ALLOC, 12'd0));

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part. The block is still clearing its bitmap; send_word waits on busy.
    foreach (plan[i]) begin
      if (plan[i].kind == ROW_REG) begin
        drain();
        write_reg(plan[i].reg_sel, plan[i].reg_val);
      end else begin
        gap = (i + 1 < plan.size() && plan[i + 1].kind == ROW_WORD) ? 0 : 1;
        send_word(plan[i].act, plan[i].idx, gap, plan[i].known, plan[i].want);
      end
    end

    // Random part: three idle profiles, six windows each, 29 words per window.
    // Windows are reprogrammed only once every owed word is back.
    for (int ph = 0; ph < 3; ph++) begin
      pct = (ph == 0) ? 28 : (ph == 1) ? 52 : 0;
      for (int w = 0; w < 6; w++) begin
        r = $urandom_range(9);
        if (r == 0) begin
          tot = $urandom_range(1) ? 4096 : 8191;
          fst = $urandom_range(4095);
        end else if (r == 1) begin
          tot = $urandom_range(8191);
          fst = $urandom_range(8191);
        end else begin
          // narrow window in a random region, 8 to 96 entries above the floor
          fst = $urandom_range(4000);
          tot = fst + $urandom_range(8, 96);
        end
        win_hi = (tot < ENTRIES) ? tot : ENTRIES;
        drain();
        write_reg(REG_TOTAL, CFG_W'(tot));
        write_reg(REG_FIRST, CFG_W'(fst));
        for (int k = 0; k < 29; k++) begin
          idx = IDX_W'($urandom_range(4095));
          if ($urandom_range(99) < 75) begin
            act = ACT_ALLOC;
          end else begin
            act = ACT_TAS;
            r = $urandom_range(9);
            if (r < 6 && win_hi > fst) begin
              idx = IDX_W'($urandom_range(win_hi - 1, fst));
            end else if (r < 8 && tot < ENTRIES) begin
              idx = IDX_W'(tot);   // first index past the limit
            end
          end
          gap = (k == 28) ? 1 : idle_gap(pct);
          send_word(act, idx, gap, 1'b0, '0);
        end
      end
    end

    drain();
    repeat (TAIL_WAIT) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("bitmap_next_fit_allocator test passed");
    end else begin
      $display("bitmap_next_fit_allocator test failed");
    end
    $finish;
  end

endmodule
